>>> sv/fwspc_pkg.sv
`default_nettype none

package fwspc_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SETPOINT   = 3'd0;
	localparam logic [2:0] REG_LEFT_RATIO = 3'd1;
	localparam logic [2:0] REG_RIGHT_RAT  = 3'd2;
	localparam logic [2:0] REG_PROP_GAIN  = 3'd3;
	localparam logic [2:0] REG_INT_GAIN   = 3'd4;

	// Register values after reset.
	localparam logic [15:0] RST_SETPOINT  = 16'd0;
	localparam logic [15:0] RST_RATIO     = 16'd16384;
	localparam logic [15:0] RST_PROP_GAIN = 16'd2867;
	localparam logic [15:0] RST_INT_GAIN  = 16'd0;

	// rpm = floor(count * 150 / 23); the division is a multiplication by
	// ceil(2^29 / 23), which is exact for every dividend below 2^24.
	localparam logic [24:0] RPM_RECIP = 25'd23342214;

	// Shared multiplier operand selection.
	localparam logic [2:0] MUL_NONE = 3'd0;
	localparam logic [2:0] MUL_RPM  = 3'd1;
	localparam logic [2:0] MUL_TGT  = 3'd2;
	localparam logic [2:0] MUL_KP   = 3'd3;
	localparam logic [2:0] MUL_KI   = 3'd4;

	// Accumulator operations.
	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// Jump kinds at the end of a wheel.
	localparam logic JMP_NONE  = 1'b0;
	localparam logic JMP_WHEEL = 1'b1;

	localparam int STEP_W = 3;

	// One control word of the sequencer program.
	typedef struct packed {
		logic       ld_x;
		logic [2:0] mul_op;
		logic       ld_rpm;
		logic       ld_err;
		logic       ld_sum;
		logic [1:0] acc_op;
		logic       emit;
		logic       jmp;
	} uword_t;

	// Program for one wheel, eight steps.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{ld_x: 1'b0, mul_op: MUL_NONE, ld_rpm: 1'b0, ld_err: 1'b0, ld_sum: 1'b0,
		       acc_op: ACC_NONE, emit: 1'b0, jmp: JMP_NONE};
		case (step)
			3'd0: w.ld_x = 1'b1;
			3'd1: w.mul_op = MUL_RPM;
			3'd2: begin
				w.ld_rpm = 1'b1;
				w.mul_op = MUL_TGT;
			end
			3'd3: w.ld_err = 1'b1;
			3'd4: begin
				w.ld_sum = 1'b1;
				w.mul_op = MUL_KP;
			end
			3'd5: begin
				w.acc_op = ACC_LOAD;
				w.mul_op = MUL_KI;
			end
			3'd6: w.acc_op = ACC_ADD;
			3'd7: begin
				w.emit = 1'b1;
				w.jmp  = JMP_WHEEL;
			end
			default: w.ld_x = 1'b0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> sv/four_wheel_encoder_pi_speed_control_unit.sv
// Four-wheel encoder speed controller with a PI loop per wheel.
// Input channel (in_valid/in_ready, cmd, wheel): cmd 0 is an encoder pulse on
// the given wheel, cmd 1 is a timer tick. Pulses and ordinary ticks give no
// result. The tick that follows TICKS_BEFORE_UPDATE counted ticks closes a
// control period: a microcoded sequencer walks every wheel in turn through
// eight steps on one shared multiplier (rpm, target, P and I terms).
// in_ready stays low while the sequencer runs.
// Output channel (out_valid/out_ready): one beat per wheel, last on the final
// one. A result waits in the output register; if the receiver stalls, the
// sequencer holds at its emit step until the register is free.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; unknown indexes are ignored.
// Reset clears pulse counts, integrators and the tick count and restores the
// register defaults; no clearing pass is needed.
`default_nettype none

module four_wheel_encoder_pi_speed_control_unit
	import fwspc_pkg::*;
#(
	parameter int WHEELS              = 4,
	parameter int TICKS_BEFORE_UPDATE = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [1:0]  wheel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       wheel_index,
	output logic [15:0]      speed_rpm,
	output logic [7:0]       duty,
	output logic             last
);

	localparam int WW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

	// Configuration registers.
	logic [15:0] setpoint_q, left_ratio_q, right_ratio_q, kp_q, ki_q;

	// Wheel state.
	logic [15:0]        pulse_q [WHEELS];
	logic signed [31:0] esum_q  [WHEELS];
	logic [3:0]         tick_q;

	// Sequencer.
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [WW-1:0]     w_q;
	uword_t            uw;

	// Datapath registers.
	logic [23:0]        x_q;
	logic signed [58:0] prod_q;
	logic [15:0]        rpm_q;
	logic signed [18:0] err_q;
	logic signed [31:0] sum_q;
	logic signed [49:0] acc_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  wheel_index_q;
	logic [15:0] speed_rpm_q;
	logic [7:0]  duty_q;
	logic        last_q;

	logic               in_fire, out_free, emit_fire, advance, last_wheel;
	logic [WW-1:0]      addr;
	logic [15:0]        cnt_rd;
	logic [23:0]        x_d;
	logic signed [32:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [58:0] prod_d;
	logic [15:0]        rpm_d;
	logic signed [18:0] err_d;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_d;
	logic [15:0]        ratio;
	logic [7:0]         duty_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign in_fire   = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign wheel_index = wheel_index_q;
	assign speed_rpm   = speed_rpm_q;
	assign duty        = duty_q;
	assign last        = last_q;

	// Current control word and handshake with the output register.
	assign uw         = ucode(step_q);
	assign out_free   = !out_valid_q || out_ready;
	assign emit_fire  = busy_q && uw.emit && out_free;
	assign advance    = busy_q && (!uw.emit || out_free);
	assign last_wheel = (w_q == WW'(WHEELS - 1));

	// One read port on the pulse counters: the sequencer owns it while busy.
	assign addr   = busy_q ? w_q : WW'(wheel);
	assign cnt_rd = pulse_q[addr];

	// Count times 150 by shifts and adds.
	assign x_d = ({8'd0, cnt_rd} << 7) + ({8'd0, cnt_rd} << 4)
	           + ({8'd0, cnt_rd} << 2) + ({8'd0, cnt_rd} << 1);

	assign ratio = (32'(w_q) < WHEELS / 2) ? right_ratio_q : left_ratio_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (uw.mul_op)
			MUL_RPM: begin
				mul_a = {9'd0, x_q};
				mul_b = {1'b0, RPM_RECIP};
			end
			MUL_TGT: begin
				mul_a = {17'd0, setpoint_q};
				mul_b = {10'd0, ratio};
			end
			MUL_KP: begin
				mul_a = {{14{err_q[18]}}, err_q};
				mul_b = {10'd0, kp_q};
			end
			MUL_KI: begin
				mul_a = {sum_q[31], sum_q};
				mul_b = {10'd0, ki_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// rpm from the reciprocal product, saturated to 16 bits.
	assign rpm_d = (|prod_q[48:45]) ? 16'hFFFF : prod_q[44:29];

	// Speed error against the scaled setpoint.
	assign err_d = $signed({1'b0, prod_q[31:14]}) - $signed({3'd0, rpm_q});

	// Saturating integrator update.
	always_comb begin
		sum_wide = {esum_q[w_q][31], esum_q[w_q]} + {{14{err_q[18]}}, err_q};
		if (sum_wide[32] != sum_wide[31]) begin
			sum_d = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum_d = sum_wide[31:0];
		end
	end

	// Duty from the Q.16 control value, clamped to 0..255.
	always_comb begin
		if (acc_q[49] || acc_q == '0) begin
			duty_d = 8'd0;
		end else if (|acc_q[48:24]) begin
			duty_d = 8'd255;
		end else begin
			duty_d = acc_q[23:16];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q    <= RST_SETPOINT;
			left_ratio_q  <= RST_RATIO;
			right_ratio_q <= RST_RATIO;
			kp_q          <= RST_PROP_GAIN;
			ki_q          <= RST_INT_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETPOINT:   setpoint_q    <= cfg_data;
				REG_LEFT_RATIO: left_ratio_q  <= cfg_data;
				REG_RIGHT_RAT:  right_ratio_q <= cfg_data;
				REG_PROP_GAIN:  kp_q          <= cfg_data;
				REG_INT_GAIN:   ki_q          <= cfg_data;
				default:        setpoint_q    <= setpoint_q;
			endcase
		end
	end

	// Pulse counters: saturating count, cleared when the sequencer reads them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				pulse_q[i] <= '0;
			end
		end else if (busy_q && uw.ld_x) begin
			pulse_q[w_q] <= '0;
		end else if (in_fire && !cmd && (32'(wheel) < WHEELS) && cnt_rd != 16'hFFFF) begin
			pulse_q[addr] <= cnt_rd + 16'd1;
		end
	end

	// Integrators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				esum_q[i] <= '0;
			end
		end else if (busy_q && uw.ld_sum) begin
			esum_q[w_q] <= sum_d;
		end
	end

	// Tick counting and sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			busy_q <= 1'b0;
			step_q <= '0;
			w_q    <= '0;
		end else if (!busy_q) begin
			if (in_fire && cmd) begin
				if (32'(tick_q) < TICKS_BEFORE_UPDATE) begin
					tick_q <= tick_q + 4'd1;
				end else begin
					tick_q <= '0;
					busy_q <= 1'b1;
					step_q <= '0;
					w_q    <= '0;
				end
			end
		end else if (advance) begin
			if (uw.jmp == JMP_WHEEL) begin
				step_q <= '0;
				if (last_wheel) begin
					busy_q <= 1'b0;
				end else begin
					w_q <= w_q + WW'(1);
				end
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Datapath registers, loaded as the control word says.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (uw.ld_x) begin
				x_q <= x_d;
			end
			if (uw.mul_op != MUL_NONE) begin
				prod_q <= prod_d;
			end
			if (uw.ld_rpm) begin
				rpm_q <= rpm_d;
			end
			if (uw.ld_err) begin
				err_q <= err_d;
			end
			if (uw.ld_sum) begin
				sum_q <= sum_d;
			end
			case (uw.acc_op)
				ACC_LOAD: acc_q <= {prod_q[45:0], 4'd0};
				ACC_ADD:  acc_q <= acc_q + prod_q[49:0];
				default:  acc_q <= acc_q;
			endcase
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			wheel_index_q <= 2'(w_q);
			speed_rpm_q   <= rpm_q;
			duty_q        <= duty_d;
			last_q        <= last_wheel;
		end
	end

	// The final beat of a period always belongs to the highest wheel.
	a_last_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> wheel_index == 2'(WHEELS - 1))
		else $error("last beat on a wheel other than the highest");

	// An encoder pulse never starts a control period.
	a_pulse_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !cmd |=> !busy_q)
		else $error("sequencer started on a pulse");

	// A finished period leaves the tick count cleared.
	a_tick_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> tick_q == 4'd0)
		else $error("tick count not cleared after a period");

	// Results only appear out of a running period.
	a_out_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy_q))
		else $error("result raised outside a control period");

endmodule

`default_nettype wire

>>> sim/testbench.sv
module testbench
	import fwspc_pkg::*;
();

	// Command codes on the input channel.
	localparam logic CMD_PULSE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// First register index that the block does not decode.
	localparam logic [2:0] REG_UNDECODED = 3'd5;

	localparam int WHEEL_COUNT  = 4;
	localparam int UPDATE_TICKS = 10;
	localparam int PERIOD_TICKS = UPDATE_TICKS + 1;
	localparam int SETTLE       = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;

	typedef struct {
		logic [1:0]  idx;
		logic [15:0] rpm;
		logic [7:0]  duty;
		logic        last;
	} wheel_report_t;

	// Tracks the controller state and the wheel reports still to come.
	class speed_scoreboard;
		logic [15:0]   setpoint;
		logic [15:0]   left_ratio;
		logic [15:0]   right_ratio;
		logic [15:0]   kp;
		logic [15:0]   ki;
		logic [3:0]    ticks;
		logic [15:0]   pulses [WHEEL_COUNT];
		int            integ [WHEEL_COUNT];
		wheel_report_t reports_due [$];
		int            errors;
		int            shown;

		function new();
			setpoint    = RST_SETPOINT;
			left_ratio  = RST_RATIO;
			right_ratio = RST_RATIO;
			kp          = RST_PROP_GAIN;
			ki          = RST_INT_GAIN;
			ticks       = '0;
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				pulses[i] = '0;
				integ[i]  = 0;
			end
			errors = 0;
			shown  = 0;
		endfunction

		function void write_register(logic [2:0] index, logic [15:0] value);
			case (index)
				REG_SETPOINT:   setpoint = value;
				REG_LEFT_RATIO: left_ratio = value;
				REG_RIGHT_RAT:  right_ratio = value;
				REG_PROP_GAIN:  kp = value;
				REG_INT_GAIN:   ki = value;
				default: ;
			endcase
		endfunction

		// Advances the controller by one accepted beat and queues any reports.
		function void note_command(logic c, logic [1:0] w);
			logic [31:0]   r;
			logic [15:0]   ratio;
			longint        target;
			longint        err;
			longint        sum;
			longint        ctl;
			wheel_report_t rep;
			if (c == CMD_PULSE) begin
				if (pulses[w] != 16'hFFFF)
					pulses[w] = pulses[w] + 16'd1;
				return;
			end
			if (ticks < UPDATE_TICKS) begin
				ticks = ticks + 4'd1;
				return;
			end
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				r = (32'(pulses[i]) * 32'd750) / 32'd115;
				if (r > 32'd65535)
					r = 32'd65535;
				pulses[i] = '0;
				ratio = (i < WHEEL_COUNT / 2) ? right_ratio : left_ratio;
				target = longint'((64'(setpoint) * 64'(ratio)) >> 14);
				err = target - longint'(r);
				sum = longint'(integ[i]) + err;
				if (sum > 64'sd2147483647)
					sum = 64'sd2147483647;
				if (sum < -64'sd2147483648)
					sum = -64'sd2147483648;
				integ[i] = int'(sum);
				ctl = err * longint'(kp) * 16 + sum * longint'(ki);
				rep.idx  = 2'(i);
				rep.rpm  = r[15:0];
				rep.last = (i == WHEEL_COUNT - 1);
				if (ctl <= 0)
					rep.duty = 8'd0;
				else if ((ctl >>> 16) > 255)
					rep.duty = 8'd255;
				else
					rep.duty = 8'(ctl >>> 16);
				reports_due.push_back(rep);
			end
			ticks = '0;
		endfunction

		function void flag(string what, longint want, longint got);
			errors++;
			if (shown < 40)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			shown++;
		endfunction

		// Compares one output beat against the oldest report due.
		function void check_beat(logic [1:0] w, logic [15:0] rpm, logic [7:0] d, logic l);
			wheel_report_t exp_rep;
			if (reports_due.size() == 0) begin
				errors++;
				if (shown < 40)
					$display("%0t: unexpected beat wheel %0d rpm %0d duty %0d last %0d",
						$time, w, rpm, d, l);
				shown++;
				return;
			end
			exp_rep = reports_due.pop_front();
			if (w !== exp_rep.idx)
				flag("wheel_index", exp_rep.idx, w);
			if (rpm !== exp_rep.rpm)
				flag("speed_rpm", exp_rep.rpm, rpm);
			if (d !== exp_rep.duty)
				flag("duty", exp_rep.duty, d);
			if (l !== exp_rep.last)
				flag("last", exp_rep.last, l);
		endfunction

		function int pending();
			return reports_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [1:0]  wheel = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  wheel_index;
	logic [15:0] speed_rpm;
	logic [7:0]  duty;
	logic        last;

	speed_scoreboard sb;
	int          idle_pct = 14;
	logic        hold_req = 1'b0;
	int          quiet_cycles = 0;

	four_wheel_encoder_pi_speed_control_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.wheel       (wheel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.wheel_index (wheel_index),
		.speed_rpm   (speed_rpm),
		.duty        (duty),
		.last        (last)
	);

	always #5 clk = ~clk;

	// Watch every channel at the rising edge and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_command(cmd, wheel);
			if (out_valid && out_ready)
				sb.check_beat(wheel_index, speed_rpm, duty, last);
		end
	end

	// Watchdog: give up when no channel has moved a beat for too long.
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver: random back-pressure, or a long hold-off when asked for.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Offers one beat, starting and ending at a falling edge.
	task automatic send_command(logic c, logic [1:0] w);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		wheel    <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_ticks(int n);
		for (int i = 0; i < n; i++)
			send_command(CMD_TICK, 2'($urandom_range(3)));
	endtask

	task automatic send_pulses(logic [1:0] w, int n);
		for (int i = 0; i < n; i++)
			send_command(CMD_PULSE, w);
	endtask

	// Writes one register; the caller drops cfg_valid after the last write.
	task automatic write_cfg(logic [2:0] index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Waits for every report due, then lets the block settle.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apply_setting(logic [15:0] sp, logic [15:0] lr, logic [15:0] rr,
			logic [15:0] p, logic [15:0] i);
		wait_quiet();
		write_cfg(REG_SETPOINT, sp);
		write_cfg(REG_LEFT_RATIO, lr);
		write_cfg(REG_RIGHT_RAT, rr);
		write_cfg(REG_PROP_GAIN, p);
		write_cfg(REG_INT_GAIN, i);
		write_cfg(REG_UNDECODED + 3'($urandom_range(2)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Mostly pulse bursts broken by ticks, so that periods close regularly.
	task automatic send_mixed(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 60)
				send_command(CMD_PULSE, 2'($urandom_range(3)));
			else
				send_command(CMD_TICK, 2'($urandom_range(3)));
		end
	endtask

	initial begin
		logic [1:0] w_full;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: one period at the register defaults with uneven counts.
		send_pulses(2'd0, 1);
		send_pulses(2'd1, 2);
		send_pulses(2'd2, 3);
		send_pulses(2'd3, 1);
		send_ticks(PERIOD_TICKS);
		send_command(CMD_PULSE, 2'd3);

		// Register extremes: everything cleared, then everything at full scale.
		apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_mixed(30);
		apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_mixed(40);

		// Random settings around the measured range of the wheels.
		for (int p = 0; p < 4; p++) begin
			apply_setting(16'($urandom_range(200)), 16'($urandom_range(32000, 8000)),
				16'($urandom_range(32000, 8000)), 16'($urandom), 16'($urandom_range(4000)));
			if (p == 1)
				hold_req = 1'b1;
			idle_pct = (p == 2) ? 0 : 14;
			send_mixed(50);
		end
		idle_pct = 14;

		// Uneven pulse counts on three wheels at a random setpoint.
		apply_setting(16'($urandom), RST_RATIO, RST_RATIO, RST_PROP_GAIN, 16'($urandom_range(50)));
		w_full = 2'($urandom_range(3));
		send_pulses(w_full, 9);
		send_pulses(w_full + 2'd1, 3);
		send_pulses(w_full + 2'd2, 1);
		send_ticks(PERIOD_TICKS);

		// Full-scale setpoint with a small integral gain over two periods, then pulled back.
		idle_pct = 0;
		apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom), 16'd1);
		send_ticks(2 * PERIOD_TICKS);
		idle_pct = 14;
		apply_setting(16'd0, RST_RATIO, RST_RATIO, 16'd0, 16'($urandom_range(300, 1)));
		send_mixed(20);

		wait_quiet();
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

>>> sim.f
sv/fwspc_pkg.sv
sv/four_wheel_encoder_pi_speed_control_unit.sv
sim/testbench.sv
